// ----- rtl/tbp_pkg.sv -----
// ----------------------------------------------------------------------------
// Tournament branch predictor package
// Table geometry, port widths, counter limits and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  // Table geometry.
  localparam int GLOBAL_HIST_BITS = 12;
  localparam int LOCAL_HIST_BITS  = 10;
  localparam int LOCAL_IDX_BITS   = 10;
  localparam int LOCAL_ENTRIES    = 1 << LOCAL_IDX_BITS;

  // The global hash takes the upper address bits from this position.
  localparam int PC_HASH_SHIFT = 20;
  localparam int PC_W          = 32;

  // The clearing sweep covers the deepest of the tables.
  localparam int CLR_W =
    (GLOBAL_HIST_BITS > LOCAL_HIST_BITS) ?
      ((GLOBAL_HIST_BITS > LOCAL_IDX_BITS) ? GLOBAL_HIST_BITS : LOCAL_IDX_BITS) :
      ((LOCAL_HIST_BITS > LOCAL_IDX_BITS) ? LOCAL_HIST_BITS : LOCAL_IDX_BITS);

  // Counter widths and limits.
  localparam int LCTR_W = 4;
  localparam int GCTR_W = 2;
  localparam logic [LCTR_W-1:0] LCTR_MAX = 4'd15;
  localparam logic [GCTR_W-1:0] GCTR_MAX = 2'd3;

  // Stream widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  // Result queue.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Request command codes.
  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_UPDATE  = 1'b1
  } cmd_t;

  // A finished prediction entering the result queue.
  typedef struct packed {
    logic valid;
    logic taken;
  } out_req_t;

endpackage

`default_nettype wire

// ----- rtl/tbp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// Result queue
// Small queue between the predictor pipeline and the output stream. The
// pipeline never stalls; the top level admits a request only while a slot is
// reserved for its result.
// ----------------------------------------------------------------------------
`default_nettype none

module tbp_out_fifo
  import tbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  out_req_t              push,
  output logic [FIFO_CNT_W-1:0] count,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_taken
);

  logic                  taken_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic                  pop;

  assign out_valid = (count != '0);
  assign out_taken = taken_q[rd_ptr];
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      taken_q[wr_ptr] <= push.taken;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/tournament_branch_predictor.sv -----
// ----------------------------------------------------------------------------
// Tournament branch predictor
// Local history predictor, global history predictor and a chooser, with
// saturating training and history shifting on update requests.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals                         Meaning
//  s_axis    in   tvalid tready tdata[39:0] tuser  predict or update request
//  m_axis    out  tvalid tready tdata[7:0]         combined prediction
//
//  One request is taken every cycle while s_axis_tready is high; a result
//  passes through the two registered table reads in series (history store,
//  then local counter) and the result queue write.
//  After reset all tables are swept to zero, one entry per cycle over 4096
//  entries (the global table depth); no request is taken during the sweep.
//  The pipeline never stalls. A four-entry result queue absorbs output stalls,
//  and s_axis_tready drops while requests in flight plus queued results fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module tournament_branch_predictor
  import tbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] pc, [32] is_cond, [33] is_call, [34] is_ret, [35] outcome, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] predict_taken, [7:1] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // Tables.
  logic [LOCAL_HIST_BITS-1:0] hist_mem [LOCAL_ENTRIES];
  logic [LCTR_W-1:0]          lctr_mem [1 << LOCAL_HIST_BITS];
  logic [GCTR_W-1:0]          gctr_mem [1 << GLOBAL_HIST_BITS];
  logic [GCTR_W-1:0]          ch_mem   [1 << GLOBAL_HIST_BITS];

  logic [GLOBAL_HIST_BITS-1:0] global_hist;

  // Clearing sweep.
  logic             clr_active;
  logic [CLR_W-1:0] clr_idx;

  // Accept side.
  logic                        acc;
  cmd_t                        in_cmd;
  logic [PC_W-1:0]             in_pc;
  logic                        in_outcome;
  logic [LOCAL_IDX_BITS-1:0]   acc_li;
  logic [GLOBAL_HIST_BITS-1:0] acc_gi;

  // Stage 1: history store data.
  logic                        s1_valid;
  cmd_t                        s1_cmd;
  logic                        s1_uncond;
  logic                        s1_outcome;
  logic [LOCAL_IDX_BITS-1:0]   s1_li;
  logic [GLOBAL_HIST_BITS-1:0] s1_gi;
  logic [LOCAL_HIST_BITS-1:0]  hist_rdata;
  logic                        byp_hit;
  logic [LOCAL_HIST_BITS-1:0]  byp_val;
  logic [LOCAL_HIST_BITS-1:0]  s1_lh;
  logic [LOCAL_HIST_BITS-1:0]  s1_hist_new;
  logic                        hist_we;

  // Stage 2: counter data, prediction and training.
  logic                        s2_valid;
  cmd_t                        s2_cmd;
  logic                        s2_uncond;
  logic                        s2_outcome;
  logic [GLOBAL_HIST_BITS-1:0] s2_gi;
  logic [LOCAL_HIST_BITS-1:0]  s2_lh;
  logic [LCTR_W-1:0]           lctr_rdata;
  logic [GCTR_W-1:0]           gctr_rdata;
  logic [GCTR_W-1:0]           ch_rdata;
  logic [LCTR_W-1:0]           lc;
  logic [GCTR_W-1:0]           gc;
  logic [GCTR_W-1:0]           ch;
  logic                        lp;
  logic                        gp;
  logic                        pred;
  logic [LCTR_W-1:0]           lc_next;
  logic [GCTR_W-1:0]           gc_next;
  logic [GCTR_W-1:0]           ch_dec;
  logic [GCTR_W-1:0]           ch_next;
  logic                        ctr_we;

  // Last counter write, for the read that was issued alongside it.
  logic                        lw_valid;
  logic [LOCAL_HIST_BITS-1:0]  lw_lh;
  logic [GLOBAL_HIST_BITS-1:0] lw_gi;
  logic [LCTR_W-1:0]           lw_lctr;
  logic [GCTR_W-1:0]           lw_gctr;
  logic [GCTR_W-1:0]           lw_ch;

  // Result queue.
  out_req_t              res_push;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W-1:0] occupancy;
  logic                  fifo_taken;

  // --------------------------------------------------------------------------
  // Admission and request decode
  // --------------------------------------------------------------------------
  assign occupancy = FIFO_CNT_W'(s1_valid) + FIFO_CNT_W'(s2_valid) + fifo_count;
  assign s_axis_tready = !clr_active && (occupancy < FIFO_CNT_W'(FIFO_DEPTH));
  assign acc = s_axis_tvalid & s_axis_tready;

  assign in_cmd     = cmd_t'(s_axis_tuser);
  assign in_pc      = s_axis_tdata[PC_W-1:0];
  assign in_outcome = s_axis_tdata[35];
  assign acc_li     = in_pc[LOCAL_IDX_BITS-1:0];
  assign acc_gi     = global_hist ^ GLOBAL_HIST_BITS'(in_pc >> PC_HASH_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      clr_idx <= clr_idx + CLR_W'(1);
      if (clr_idx == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  // The global history is known at admission, so it moves right away.
  always_ff @(posedge clk) begin
    if (rst) begin
      global_hist <= '0;
    end else if (acc && in_cmd == CMD_UPDATE) begin
      global_hist <= {global_hist[GLOBAL_HIST_BITS-2:0], in_outcome};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      s1_valid <= acc;
      // The request now in stage 1 writes its history as this read happens.
      byp_hit  <= acc && hist_we && (s1_li == acc_li);
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd     <= in_cmd;
    s1_uncond  <= !s_axis_tdata[32] || s_axis_tdata[33] || s_axis_tdata[34];
    s1_outcome <= in_outcome;
    s1_li      <= acc_li;
    s1_gi      <= acc_gi;
    byp_val    <= s1_hist_new;
  end

  always_ff @(posedge clk) begin
    hist_rdata <= hist_mem[acc_li];
    if (clr_active) begin
      hist_mem[clr_idx[LOCAL_IDX_BITS-1:0]] <= '0;
    end else if (hist_we) begin
      hist_mem[s1_li] <= s1_hist_new;
    end
  end

  assign s1_lh       = byp_hit ? byp_val : hist_rdata;
  assign s1_hist_new = {s1_lh[LOCAL_HIST_BITS-2:0], s1_outcome};
  assign hist_we     = s1_valid && s1_cmd == CMD_UPDATE;

  // --------------------------------------------------------------------------
  // Stage 2
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      lw_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
      lw_valid <= ctr_we;
    end
  end

  always_ff @(posedge clk) begin
    s2_cmd     <= s1_cmd;
    s2_uncond  <= s1_uncond;
    s2_outcome <= s1_outcome;
    s2_gi      <= s1_gi;
    s2_lh      <= s1_lh;
    lw_lh      <= s2_lh;
    lw_gi      <= s2_gi;
    lw_lctr    <= lc_next;
    lw_gctr    <= gc_next;
    lw_ch      <= ch_next;
  end

  always_ff @(posedge clk) begin
    lctr_rdata <= lctr_mem[s1_lh];
    if (clr_active) begin
      lctr_mem[clr_idx[LOCAL_HIST_BITS-1:0]] <= '0;
    end else if (ctr_we) begin
      lctr_mem[s2_lh] <= lc_next;
    end
  end

  always_ff @(posedge clk) begin
    gctr_rdata <= gctr_mem[s1_gi];
    if (clr_active) begin
      gctr_mem[clr_idx[GLOBAL_HIST_BITS-1:0]] <= '0;
    end else if (ctr_we) begin
      gctr_mem[s2_gi] <= gc_next;
    end
  end

  always_ff @(posedge clk) begin
    ch_rdata <= ch_mem[s1_gi];
    if (clr_active) begin
      ch_mem[clr_idx[GLOBAL_HIST_BITS-1:0]] <= '0;
    end else if (ctr_we) begin
      ch_mem[s2_gi] <= ch_next;
    end
  end

  // The write from the previous cycle is not yet in the read data.
  assign lc = (lw_valid && lw_lh == s2_lh) ? lw_lctr : lctr_rdata;
  assign gc = (lw_valid && lw_gi == s2_gi) ? lw_gctr : gctr_rdata;
  assign ch = (lw_valid && lw_gi == s2_gi) ? lw_ch   : ch_rdata;

  assign lp     = lc[LCTR_W-1];
  assign gp     = gc[GCTR_W-1];
  assign ctr_we = s2_valid && s2_cmd == CMD_UPDATE;

  always_comb begin
    if (lp == gp) begin
      pred = lp;
    end else begin
      pred = ch[GCTR_W-1] ? gp : lp;
    end
    if (s2_uncond) begin
      pred = 1'b1;
    end

    if (s2_outcome) begin
      lc_next = (lc == LCTR_MAX) ? lc : lc + LCTR_W'(1);
      gc_next = (gc == GCTR_MAX) ? gc : gc + GCTR_W'(1);
    end else begin
      lc_next = (lc == '0) ? lc : lc - LCTR_W'(1);
      gc_next = (gc == '0) ? gc : gc - GCTR_W'(1);
    end

    // The chooser first steps down for a correct local guess, then up for a
    // correct global guess.
    ch_dec  = (s2_outcome == lp && ch != '0) ? ch - GCTR_W'(1) : ch;
    ch_next = (s2_outcome == gp && ch_dec != GCTR_MAX) ? ch_dec + GCTR_W'(1) : ch_dec;
  end

  // --------------------------------------------------------------------------
  // Result queue
  // --------------------------------------------------------------------------
  assign res_push.valid = s2_valid;
  assign res_push.taken = pred;

  tbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .count     (fifo_count),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_taken (fifo_taken)
  );

  assign m_axis_tdata = {(OUT_TDATA_W-1)'(0), fifo_taken};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    clr_active |-> !s_axis_tready)
    else $error("request admitted during table clear");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("more requests in flight than result slots");

  a_bypass_live: assert property (@(posedge clk) disable iff (rst)
    byp_hit |-> s1_valid)
    else $error("history bypass without a stage 1 request");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> s2_valid)
    else $error("stage 1 request lost");

  a_last_write: assert property (@(posedge clk) disable iff (rst)
    ctr_we |=> lw_valid)
    else $error("counter write not recorded for forwarding");

endmodule

`default_nettype wire
